@@ hw/rtl/dpb_pkg.sv @@
// Shared types, constants and helpers for the depth pixel back-projection unit.
package dpb_pkg;

   localparam int NUM_STAGES = 5;

   localparam int DEPTH_W  = 16;
   localparam int PIX_W    = 12;
   localparam int SCALE_W  = 24;
   localparam int INV_W    = 24;
   localparam int CENTER_W = 16;
   localparam int POINT_W  = 32;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;

   // Z kept at full precision: Q16.24
   localparam int Z_W     = DEPTH_W + SCALE_W;
   localparam int Z_LO_W  = 20;
   localparam int Z_HI_W  = Z_W - Z_LO_W;
   // low half of offset*reciprocal product when split for the wide multiply
   localparam int M1_LO_W = 21;
   // Q.52 product back to Q16.16
   localparam int ROUND_SHIFT = 36;
   localparam int SAT_IN_W    = 48;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_DEPTH_SCALE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INV_FOCAL_X = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_INV_FOCAL_Y = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_X    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_Y    = 3'd4;

   // reset values
   localparam logic [SCALE_W-1:0]  RST_DEPTH_SCALE = 24'd16777;
   localparam logic [INV_W-1:0]    RST_INV_FOCAL   = 24'd16777;
   localparam logic [CENTER_W-1:0] RST_CENTER_X    = 16'd5120;
   localparam logic [CENTER_W-1:0] RST_CENTER_Y    = 16'd3840;

   localparam logic [SAT_IN_W-1:0] SAT_LIMIT = 48'h0000_8000_0000;
   localparam logic [POINT_W-1:0]  POINT_MAX = 32'h7FFF_FFFF;
   localparam logic [POINT_W-1:0]  POINT_MIN = 32'h8000_0000;

   // per-stage load enables, stage 1 nearest the input
   typedef struct packed {
      logic s1;
      logic s2;
      logic s3;
      logic s4;
      logic s5;
   } dpb_adv_type;

   // magnitude and sign to saturated two's complement Q16.16
   function automatic logic signed [POINT_W-1:0] sat_q16(
      input logic [SAT_IN_W-1:0] mag,
      input logic                neg
   );
      logic [POINT_W-1:0] res;
      if (neg) begin
         if (mag >= SAT_LIMIT) res = POINT_MIN;
         else                  res = POINT_W'(0) - mag[POINT_W-1:0];
      end else begin
         if (mag > SAT_IN_W'(POINT_MAX)) res = POINT_MAX;
         else                            res = mag[POINT_W-1:0];
      end
      return signed'(res);
   endfunction

endpackage

@@ hw/rtl/dpb_req_if.sv @@
// Input channel: one depth pixel with its column and row.
interface dpb_req_if;
   logic                       valid;
   logic                       ready;
   logic [dpb_pkg::DEPTH_W-1:0] depth_raw;
   logic [dpb_pkg::PIX_W-1:0]   pixel_col;
   logic [dpb_pkg::PIX_W-1:0]   pixel_row;

   modport source (output valid, depth_raw, pixel_col, pixel_row, input ready);
   modport sink   (input valid, depth_raw, pixel_col, pixel_row, output ready);
endinterface

@@ hw/rtl/dpb_rsp_if.sv @@
// Result channel: one back-projected point (Z, X, Y).
interface dpb_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [dpb_pkg::POINT_W-1:0] point_forward;
   logic signed [dpb_pkg::POINT_W-1:0] point_lateral;
   logic signed [dpb_pkg::POINT_W-1:0] point_vertical;

   modport source (output valid, point_forward, point_lateral, point_vertical, input ready);
   modport sink   (input valid, point_forward, point_lateral, point_vertical, output ready);
endinterface

@@ hw/rtl/depth_pixel_backprojection_unit.sv @@
// Top level of the pinhole depth pixel back-projection unit.
//
// Usage
//  - req_if (sink): one transfer per pixel carrying depth_raw, pixel_col,
//    pixel_row. Only the low COORD_BITS bits of the coordinates are used.
//  - rsp_if (source): one transfer per point (Z, X, Y), signed Q16.16 metres,
//    saturated. A pixel with zero depth is taken and gives no point.
//  - csr_*: plain write port for scale, reciprocal focal lengths and principal
//    point. Write only while the pipeline is empty.
//  - Pipeline: five register stages: offset and depth*scale, offset*reciprocal,
//    partial products, sum and rounding, saturation/output register.
//  - Throughput: one pixel per cycle, back to back, while rsp is not stalled.
//  - Reset (synchronous): pipeline emptied, registers back to their defaults.
//  - rsp stall: each stage holds while its successor is full and stalled;
//    empty stages keep filling, so req_if.ready drops only when all five
//    stages hold a point. Nothing is dropped or repeated.
module depth_pixel_backprojection_unit #(
   parameter int COORD_BITS = 12
) (
   input  logic                              clock,
   input  logic                              reset,
   dpb_req_if.sink                           req_if,
   dpb_rsp_if.source                         rsp_if,
   input  logic                              csr_wr_en,
   input  logic [dpb_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [dpb_pkg::CSR_DATA_W-1:0]    csr_wr_data
);
   import dpb_pkg::*;

   // ---------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------
   logic [SCALE_W-1:0]  depth_scale_ff;
   logic [INV_W-1:0]    inv_focal_x_ff, inv_focal_y_ff;
   logic [CENTER_W-1:0] center_x_ff, center_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_scale_ff <= RST_DEPTH_SCALE;
         inv_focal_x_ff <= RST_INV_FOCAL;
         inv_focal_y_ff <= RST_INV_FOCAL;
         center_x_ff    <= RST_CENTER_X;
         center_y_ff    <= RST_CENTER_Y;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_DEPTH_SCALE: depth_scale_ff <= csr_wr_data[SCALE_W-1:0];
            CSR_INV_FOCAL_X: inv_focal_x_ff <= csr_wr_data[INV_W-1:0];
            CSR_INV_FOCAL_Y: inv_focal_y_ff <= csr_wr_data[INV_W-1:0];
            CSR_CENTER_X:    center_x_ff    <= csr_wr_data[CENTER_W-1:0];
            CSR_CENTER_Y:    center_y_ff    <= csr_wr_data[CENTER_W-1:0];
            default: ;  // unmapped index: ignored
         endcase
      end
   end

   // ---------------------------------------------------------------
   // Pipeline control: a stage loads when it is empty or its
   // successor loads. Bit k of valid is stage k+1.
   // ---------------------------------------------------------------
   logic [NUM_STAGES-1:0] valid_ff, valid_in;
   logic [NUM_STAGES-1:0] adv_vec;
   dpb_adv_type           adv;
   logic                  req_xfer;
   logic                  depth_nz;

   always_comb begin
      adv_vec[NUM_STAGES-1] = !valid_ff[NUM_STAGES-1] || rsp_if.ready;
      for (int k = NUM_STAGES - 2; k >= 0; k--) begin
         adv_vec[k] = !valid_ff[k] || adv_vec[k+1];
      end
   end

   assign adv = '{s1: adv_vec[0], s2: adv_vec[1], s3: adv_vec[2],
                  s4: adv_vec[3], s5: adv_vec[4]};

   assign req_if.ready = adv.s1;
   assign req_xfer     = req_if.valid && req_if.ready;
   assign depth_nz     = (req_if.depth_raw != '0);

   always_comb begin
      // zero-depth pixels are taken but never enter the pipe
      valid_in[0] = adv_vec[0] ? (req_if.valid && depth_nz) : valid_ff[0];
      for (int k = 1; k < NUM_STAGES; k++) begin
         valid_in[k] = adv_vec[k] ? valid_ff[k-1] : valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= '0;
      else       valid_ff <= valid_in;
   end

   // ---------------------------------------------------------------
   // Z path: full-precision product, then rounded and saturated,
   // then carried along to line up with X and Y.
   // ---------------------------------------------------------------
   logic [Z_W-1:0]            zfull_s1_ff;
   logic [Z_W:0]              zround;
   logic signed [POINT_W-1:0] z_s2_ff, z_s3_ff, z_s4_ff, z_s5_ff;

   assign zround = (Z_W+1)'(zfull_s1_ff) + (Z_W+1)'(128);

   always_ff @(posedge clock) begin
      if (adv.s1) zfull_s1_ff <= Z_W'(req_if.depth_raw) * Z_W'(depth_scale_ff);
      if (adv.s2) z_s2_ff     <= sat_q16(SAT_IN_W'(zround[Z_W:8]), 1'b0);
      if (adv.s3) z_s3_ff     <= z_s2_ff;
      if (adv.s4) z_s4_ff     <= z_s3_ff;
      if (adv.s5) z_s5_ff     <= z_s4_ff;
   end

   // ---------------------------------------------------------------
   // X and Y paths
   // ---------------------------------------------------------------
   logic [COORD_BITS-1:0]     col_bits, row_bits;
   logic signed [POINT_W-1:0] lateral, vertical;

   assign col_bits = COORD_BITS'(req_if.pixel_col);
   assign row_bits = COORD_BITS'(req_if.pixel_row);

   dpb_axis #(.COORD_BITS(COORD_BITS)) u_axis_x (
      .clock     (clock),
      .adv       (adv),
      .pixel     (col_bits),
      .center    (center_x_ff),
      .inv_focal (inv_focal_x_ff),
      .zfull     (zfull_s1_ff),
      .point     (lateral)
   );

   dpb_axis #(.COORD_BITS(COORD_BITS)) u_axis_y (
      .clock     (clock),
      .adv       (adv),
      .pixel     (row_bits),
      .center    (center_y_ff),
      .inv_focal (inv_focal_y_ff),
      .zfull     (zfull_s1_ff),
      .point     (vertical)
   );

   // ---------------------------------------------------------------
   // Result channel: stage 5 is the output register
   // ---------------------------------------------------------------
   assign rsp_if.valid          = valid_ff[NUM_STAGES-1];
   assign rsp_if.point_forward  = z_s5_ff;
   assign rsp_if.point_lateral  = lateral;
   assign rsp_if.point_vertical = vertical;

   // ---------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------
   a_zero_depth_dropped: assert property (@(posedge clock) disable iff (reset)
      req_xfer && !depth_nz |=> !valid_ff[0])
      else $error("zero-depth pixel entered the pipeline");

   a_nonzero_depth_enters: assert property (@(posedge clock) disable iff (reset)
      req_xfer && depth_nz |=> valid_ff[0])
      else $error("accepted pixel lost at stage 1");

   a_ready_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_if.ready |-> (&valid_ff))
      else $error("input stalled with a bubble in the pipeline");

   a_stage4_drains: assert property (@(posedge clock) disable iff (reset)
      valid_ff[NUM_STAGES-2] && adv.s5 |=> rsp_if.valid)
      else $error("stage 4 point did not reach the output register");

   a_forward_nonneg: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid |-> !rsp_if.point_forward[POINT_W-1])
      else $error("negative Z on output");

endmodule

@@ hw/rtl/dpb_axis.sv @@
// One axis, X or Y: pixel offset, reciprocal and Z product, rounding and saturation.
module dpb_axis #(
   parameter int COORD_BITS = 12
) (
   input  logic                            clock,
   input  dpb_pkg::dpb_adv_type            adv,
   input  logic [COORD_BITS-1:0]           pixel,
   input  logic [dpb_pkg::CENTER_W-1:0]    center,
   input  logic [dpb_pkg::INV_W-1:0]       inv_focal,
   input  logic [dpb_pkg::Z_W-1:0]         zfull,
   output logic signed [dpb_pkg::POINT_W-1:0] point
);
   import dpb_pkg::*;

   localparam int PIX4_W = COORD_BITS + 4;
   localparam int DW     = (PIX4_W > CENTER_W) ? PIX4_W : CENTER_W;
   localparam int DX     = DW + 1;
   localparam int M1W    = DW + INV_W;
   localparam int HI_W   = M1W - M1_LO_W;
   localparam int HP_W   = HI_W + Z_HI_W;
   localparam int HL_W   = HI_W + Z_LO_W;
   localparam int LH_W   = M1_LO_W + Z_HI_W;
   localparam int LL_W   = M1_LO_W + Z_LO_W;
   localparam int PSW    = M1W + Z_W + 1;
   localparam int MAG_W  = PSW - ROUND_SHIFT;

   // stage 1: signed offset (pixel << 4) - centre as sign and magnitude
   logic [DX-1:0] pix_ext, ctr_ext, diff;
   logic          neg_s1_in, neg_s1_ff;
   logic [DW-1:0] dmag_s1_in, dmag_s1_ff;

   always_comb begin
      pix_ext    = DX'({pixel, 4'b0000});
      ctr_ext    = DX'(center);
      diff       = pix_ext - ctr_ext;
      neg_s1_in  = diff[DX-1];
      dmag_s1_in = neg_s1_in ? DW'(ctr_ext - pix_ext) : diff[DW-1:0];
   end

   always_ff @(posedge clock) begin
      if (adv.s1) begin
         dmag_s1_ff <= dmag_s1_in;
         neg_s1_ff  <= neg_s1_in;
      end
   end

   // stage 2: offset times reciprocal
   logic [M1W-1:0] m1_s2_ff;
   logic [Z_W-1:0] z_s2_ff;
   logic           neg_s2_ff;

   always_ff @(posedge clock) begin
      if (adv.s2) begin
         m1_s2_ff  <= M1W'(dmag_s1_ff) * M1W'(inv_focal);
         z_s2_ff   <= zfull;
         neg_s2_ff <= neg_s1_ff;
      end
   end

   // stage 3: four partial products of the wide multiply
   logic [HP_W-1:0] pp_hh_ff;
   logic [HL_W-1:0] pp_hl_ff;
   logic [LH_W-1:0] pp_lh_ff;
   logic [LL_W-1:0] pp_ll_ff;
   logic            neg_s3_ff;

   always_ff @(posedge clock) begin
      if (adv.s3) begin
         pp_hh_ff  <= HP_W'(m1_s2_ff[M1W-1:M1_LO_W]) * HP_W'(z_s2_ff[Z_W-1:Z_LO_W]);
         pp_hl_ff  <= HL_W'(m1_s2_ff[M1W-1:M1_LO_W]) * HL_W'(z_s2_ff[Z_LO_W-1:0]);
         pp_lh_ff  <= LH_W'(m1_s2_ff[M1_LO_W-1:0]) * LH_W'(z_s2_ff[Z_W-1:Z_LO_W]);
         pp_ll_ff  <= LL_W'(m1_s2_ff[M1_LO_W-1:0]) * LL_W'(z_s2_ff[Z_LO_W-1:0]);
         neg_s3_ff <= neg_s2_ff;
      end
   end

   // stage 4: recombine and round half away from zero (magnitude form)
   logic [PSW-1:0]   psum;
   logic [MAG_W-1:0] mag_s4_ff;
   logic             neg_s4_ff;

   always_comb begin
      psum = (PSW'(pp_hh_ff) << (M1_LO_W + Z_LO_W))
           + (PSW'(pp_hl_ff) << M1_LO_W)
           + (PSW'(pp_lh_ff) << Z_LO_W)
           + PSW'(pp_ll_ff)
           + (PSW'(1) << (ROUND_SHIFT - 1));
   end

   always_ff @(posedge clock) begin
      if (adv.s4) begin
         mag_s4_ff <= psum[PSW-1:ROUND_SHIFT];
         neg_s4_ff <= neg_s3_ff;
      end
   end

   // stage 5: saturate, apply sign
   logic signed [POINT_W-1:0] point_ff;

   always_ff @(posedge clock) begin
      if (adv.s5) begin
         point_ff <= sat_q16(SAT_IN_W'(mag_s4_ff), neg_s4_ff);
      end
   end

   assign point = point_ff;

endmodule

@@ bench/point_check_pkg.sv @@
`timescale 1ns / 100ps
// Point predictor and scoreboard for the depth pixel back-projection bench.
package point_check_pkg;
   import dpb_pkg::*;

   typedef struct packed {
      logic signed [POINT_W-1:0] forward;
      logic signed [POINT_W-1:0] lateral;
      logic signed [POINT_W-1:0] vertical;
   } dpb_point_type;

   class point_scoreboard;
      dpb_point_type       expected_points[$];
      logic [SCALE_W-1:0]  scale;
      logic [INV_W-1:0]    inv_x;
      logic [INV_W-1:0]    inv_y;
      logic [CENTER_W-1:0] cen_x;
      logic [CENTER_W-1:0] cen_y;
      logic [PIX_W-1:0]    coord_mask;
      int unsigned         errors;
      int unsigned         pixels_noted;
      int unsigned         blank_pixels;
      int unsigned         points_checked;
      int unsigned         clipped;

      function new(int coord_bits);
         coord_mask     = PIX_W'((1 << coord_bits) - 1);
         scale          = RST_DEPTH_SCALE;
         inv_x          = RST_INV_FOCAL;
         inv_y          = RST_INV_FOCAL;
         cen_x          = RST_CENTER_X;
         cen_y          = RST_CENTER_Y;
         errors         = 0;
         pixels_noted   = 0;
         blank_pixels   = 0;
         points_checked = 0;
         clipped        = 0;
      endfunction

      // unknown indexes are dropped, as in the block
      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_DEPTH_SCALE: scale = data[SCALE_W-1:0];
            CSR_INV_FOCAL_X: inv_x = data[INV_W-1:0];
            CSR_INV_FOCAL_Y: inv_y = data[INV_W-1:0];
            CSR_CENTER_X:    cen_x = data[CENTER_W-1:0];
            CSR_CENTER_Y:    cen_y = data[CENTER_W-1:0];
            default: ;
         endcase
      endfunction

      function logic signed [POINT_W-1:0] saturate(logic [63:0] mag, logic neg);
         if (neg) begin
            if (mag >= 64'h8000_0000) begin
               clipped++;
               return POINT_MIN;
            end
            return signed'(POINT_W'(0) - mag[POINT_W-1:0]);
         end
         if (mag > 64'h7FFF_FFFF) begin
            clipped++;
            return POINT_MAX;
         end
         return signed'(mag[POINT_W-1:0]);
      endfunction

      // (pixel.4 - centre) * Z * reciprocal, exact Q.52, rounded half away from zero
      function logic signed [POINT_W-1:0] offset_term(logic [PIX_W-1:0] pix,
                                                     logic [CENTER_W-1:0] centre,
                                                     logic [Z_W-1:0] zfull,
                                                     logic [INV_W-1:0] recip);
         logic [16:0]  p4;
         logic [16:0]  c;
         logic [16:0]  dmag;
         logic         neg;
         logic [127:0] prod;
         logic [63:0]  mag;
         p4   = {1'b0, pix, 4'b0000};
         c    = {1'b0, centre};
         neg  = p4 < c;
         dmag = neg ? c - p4 : p4 - c;
         prod = 128'(dmag) * 128'(recip) * 128'(zfull) + (128'd1 << (ROUND_SHIFT - 1));
         mag  = 64'(prod >> ROUND_SHIFT);
         if (mag == 0) neg = 1'b0;
         return saturate(mag, neg);
      endfunction

      function void note_pixel(logic [DEPTH_W-1:0] depth, logic [PIX_W-1:0] col,
                               logic [PIX_W-1:0] row);
         logic [Z_W-1:0] zfull;
         dpb_point_type  pt;
         pixels_noted++;
         if (depth == 0) begin
            blank_pixels++;
            return;
         end
         zfull       = Z_W'(depth) * Z_W'(scale);
         pt.forward  = saturate((64'(zfull) + 64'd128) >> 8, 1'b0);
         pt.lateral  = offset_term(col & coord_mask, cen_x, zfull, inv_x);
         pt.vertical = offset_term(row & coord_mask, cen_y, zfull, inv_y);
         expected_points = {expected_points, pt};
      endfunction

      task report(string msg);
         $display("%0t ERROR: %s", $time, msg);
         errors++;
      endtask

      task check_point(logic signed [POINT_W-1:0] fwd, logic signed [POINT_W-1:0] lat,
                       logic signed [POINT_W-1:0] vert);
         dpb_point_type want;
         if (expected_points.size() == 0) begin
            report($sformatf("point %08h %08h %08h with no pixel pending", fwd, lat, vert));
            return;
         end
         want = expected_points.pop_front();
         if (fwd !== want.forward)
            report($sformatf("point %0d forward got %08h exp %08h",
                             points_checked, fwd, want.forward));
         if (lat !== want.lateral)
            report($sformatf("point %0d lateral got %08h exp %08h",
                             points_checked, lat, want.lateral));
         if (vert !== want.vertical)
            report($sformatf("point %0d vertical got %08h exp %08h",
                             points_checked, vert, want.vertical));
         points_checked++;
      endtask

      task check_leftovers();
         if (expected_points.size() != 0)
            report($sformatf("%0d points never arrived", expected_points.size()));
      endtask

      function int pending();
         return expected_points.size();
      endfunction
   endclass

endpackage

@@ bench/tb_top.sv @@
`timescale 1ns / 100ps
// Top-level bench: drives pixels and calibration into the unit and checks every point.
module tb_top;
   import dpb_pkg::*;
   import point_check_pkg::*;

   localparam int TB_COORD_BITS = 12;
   localparam int CLK_PERIOD    = 8;
   localparam int SEGMENTS      = 13;     // 13 x 150 = 1950 random pixels
   localparam int SEG_PIXELS    = 150;
   localparam int SETTLE_CYCLES = NUM_STAGES + 3;
   localparam int DRAIN_LIMIT   = 20000;
   localparam int HOLD_CYCLES   = 64;     // well beyond the five pipeline stages
   localparam longint WATCHDOG_NS = 64'd4_000_000;

   logic                  clock;
   logic                  reset;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wr_data;

   dpb_req_if req_ch();
   dpb_rsp_if rsp_ch();

   // idle chances in percent, per cycle
   int unsigned src_idle_pct;
   int unsigned dst_idle_pct;
   // receiver hold-off, counted down by the result process
   int unsigned hold_off_left;
   int unsigned settings_used;

   point_scoreboard points;

   depth_pixel_backprojection_unit #(
      .COORD_BITS(TB_COORD_BITS)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_if     (req_ch),
      .rsp_if     (rsp_ch),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wr_data(csr_wr_data)
   );

   initial begin : clock_gen
      clock = 1'b0;
      forever #(CLK_PERIOD / 2) clock = ~clock;
   end

   // Hard stop in case a transfer never completes.
   initial begin : watchdog
      #(WATCHDOG_NS);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // Result side: ready is set at the falling edge, a transfer is taken at the rising edge.
   // A pending hold-off keeps ready low for its whole count, so the pipeline backs up.
   initial begin : point_sink
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_left != 0) begin
            rsp_ch.ready  <= 1'b0;
            hold_off_left <= hold_off_left - 1;
         end else begin
            rsp_ch.ready <= ($urandom_range(0, 99) >= dst_idle_pct);
         end
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready)
            points.check_point(rsp_ch.point_forward, rsp_ch.point_lateral,
                               rsp_ch.point_vertical);
      end
   end

   // Offer one pixel and wait for its transfer. Entered and left at a falling edge;
   // valid stays high on exit so a following pixel can go back to back.
   task automatic send_pixel(input logic [DEPTH_W-1:0] depth, input logic [PIX_W-1:0] col,
                             input logic [PIX_W-1:0] row);
      while ($urandom_range(0, 99) < src_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.depth_raw <= depth;
      req_ch.pixel_col <= col;
      req_ch.pixel_row <= row;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      points.note_pixel(depth, col, row);
      @(negedge clock);
   endtask

   // Stop offering and wait for every outstanding point, bounded.
   task automatic wait_for_points(input int unsigned limit);
      int unsigned n;
      n = 0;
      req_ch.valid <= 1'b0;
      while (points.pending() != 0 && n < limit) begin
         @(negedge clock);
         n++;
      end
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= data;
      points.write_reg(idx, data);
      @(negedge clock);
   endtask

   // Calibration is only loaded with the pipeline empty. Zero-depth pixels never enter
   // the stages and leave no point behind; a settling wait follows the last point.
   // Unused upper data bits of the centre writes are randomised; the block must drop them.
   task automatic load_calibration(input logic [SCALE_W-1:0] scale, input logic [INV_W-1:0] inv_x,
                                   input logic [INV_W-1:0] inv_y, input logic [CENTER_W-1:0] cx,
                                   input logic [CENTER_W-1:0] cy);
      wait_for_points(DRAIN_LIMIT);
      repeat (SETTLE_CYCLES) @(negedge clock);
      write_reg(CSR_DEPTH_SCALE, scale);
      write_reg(CSR_INV_FOCAL_X, inv_x);
      write_reg(CSR_INV_FOCAL_Y, inv_y);
      write_reg(CSR_CENTER_X, {8'($urandom()), cx});
      write_reg(CSR_CENTER_Y, {8'($urandom()), cy});
      // an index past the end of the map must change nothing
      write_reg(CSR_CENTER_Y + CSR_IDX_W'($urandom_range(1, 3)), CSR_DATA_W'($urandom()));
      csr_wr_en <= 1'b0;
      settings_used++;
   endtask

   // Mostly camera-like calibration; one time in four anything at all.
   task automatic random_calibration();
      if ($urandom_range(0, 3) == 0)
         load_calibration(SCALE_W'($urandom()), INV_W'($urandom()), INV_W'($urandom()),
                          CENTER_W'($urandom()), CENTER_W'($urandom()));
      else
         load_calibration(SCALE_W'($urandom_range(1000, 70000)),
                          INV_W'($urandom_range(8000, 90000)),
                          INV_W'($urandom_range(8000, 90000)),
                          CENTER_W'($urandom_range(0, 4095 * 16)),
                          CENTER_W'($urandom_range(0, 4095 * 16)));
   endtask

   function automatic logic [DEPTH_W-1:0] pick_depth();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         2:       return DEPTH_W'($urandom_range(1, 255));
         default: return DEPTH_W'($urandom());
      endcase
   endfunction

   function automatic logic [PIX_W-1:0] pick_coord();
      case ($urandom_range(0, 19))
         0:       return '0;
         1:       return '1;
         default: return PIX_W'($urandom());
      endcase
   endfunction

   initial begin : stimulus
      points        = new(TB_COORD_BITS);
      reset         = 1'b1;
      csr_wr_en     = 1'b0;
      csr_index     = '0;
      csr_wr_data   = '0;
      req_ch.valid     = 1'b0;
      req_ch.depth_raw = '0;
      req_ch.pixel_col = '0;
      req_ch.pixel_row = '0;
      src_idle_pct  = 0;
      dst_idle_pct  = 0;
      hold_off_left = 0;
      settings_used = 1;   // the reset calibration
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // first idling mix for the directed part and the first random segments
      src_idle_pct = 38;
      dst_idle_pct = 51;

      // Directed, reset calibration: blank pixel, the principal point, corners, bit patterns
      send_pixel(16'h0000, 12'd0,    12'd0);
      send_pixel(16'h0001, 12'd320,  12'd240);
      send_pixel(16'hFFFF, 12'd0,    12'd0);
      send_pixel(16'hFFFF, 12'hFFF,  12'hFFF);
      send_pixel(16'd1000, 12'hFFF,  12'd0);
      send_pixel(16'h0000, 12'hFFF,  12'hFFF);
      send_pixel(16'h8000, 12'h800,  12'h800);
      send_pixel(16'h5555, 12'hAAA,  12'h555);
      send_pixel(16'hAAAA, 12'h555,  12'hAAA);

      // full-scale gains, centre at the origin: no offset is negative, large ones clip positive
      load_calibration('1, '1, '1, '0, '0);
      send_pixel(16'hFFFF, 12'hFFF, 12'hFFF);
      send_pixel(16'h0001, 12'd1,   12'd0);
      send_pixel(16'h0000, 12'hFFF, 12'hFFF);

      // centre at its top: every offset negative, large ones clip negative
      load_calibration('1, '1, '1, '1, '1);
      send_pixel(16'hFFFF, 12'd0,   12'd0);
      send_pixel(16'h0100, 12'hFFF, 12'hFFF);

      // zero scale: Z is zero, so both offsets vanish with no sign
      load_calibration('0, RST_INV_FOCAL, RST_INV_FOCAL, RST_CENTER_X, RST_CENTER_Y);
      send_pixel(16'hFFFF, 12'd0, 12'hFFF);

      // zero reciprocals: lateral and vertical forced to zero
      load_calibration(RST_DEPTH_SCALE, '0, '0, RST_CENTER_X, RST_CENTER_Y);
      send_pixel(16'hFFFF, 12'hFFF, 12'd0);
      send_pixel(16'd500,  12'd0,   12'hFFF);

      // fractional centre
      load_calibration(RST_DEPTH_SCALE, RST_INV_FOCAL, RST_INV_FOCAL, 16'h1238, 16'h0EF7);
      send_pixel(16'd1234, 12'd291, 12'd239);
      send_pixel(16'd7,    12'd292, 12'd240);

      // Random part, one calibration per segment
      for (int seg = 0; seg < SEGMENTS; seg++) begin
         random_calibration();
         if (seg == 4) begin
            src_idle_pct = 51;
            dst_idle_pct = 38;
         end else if (seg == 8) begin
            src_idle_pct = 0;
            dst_idle_pct = 0;
         end
         // long receiver hold-off while pixels keep coming: the pipeline fills
         // and req ready has to drop
         if (seg == 8 || seg == 11)
            hold_off_left <= HOLD_CYCLES;
         for (int i = 0; i < SEG_PIXELS; i++) begin
            // mid-segment the sender stops until every point is home
            if (seg == 10 && i == SEG_PIXELS / 2)
               wait_for_points(DRAIN_LIMIT);
            send_pixel(pick_depth(), pick_coord(), pick_coord());
         end
      end

      wait_for_points(DRAIN_LIMIT);
      repeat (4 * NUM_STAGES) @(negedge clock);
      points.check_leftovers();

      $display("Run covered %0d pixel transfers (%0d blank) and %0d points over %0d calibrations.",
               points.pixels_noted, points.blank_pixels, points.points_checked, settings_used);
      $display("%0d output fields clipped; sender and receiver idled in turn, with two long stalls.",
               points.clipped);
      if (points.errors == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
